### rtl/caption_presence_detector_top_macros.svh
// Assertion macros for the caption presence detector.
`ifndef CAPTION_PRESENCE_DETECTOR_TOP_MACROS_SVH
`define CAPTION_PRESENCE_DETECTOR_TOP_MACROS_SVH

// Checked while out of reset.
`define CPD_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cpd_pkg.sv
// Shared constants and types of the caption presence detector.
package cpd_pkg;

  localparam int MAX_WINDOW_PIXELS = 16384;
  localparam int SIG_WIDTH_MAX     = 32767;

  localparam int CHAN_W  = 8;
  localparam int RUN_W   = 4;
  localparam int INDEX_W = 3;

  localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

  typedef logic [1:0] status_t;
  localparam status_t ST_SAME   = 2'd0;
  localparam status_t ST_START  = 2'd1;
  localparam status_t ST_END    = 2'd2;
  localparam status_t ST_CHANGE = 2'd3;

  typedef logic [INDEX_W-1:0] reg_index_t;
  localparam reg_index_t REG_BLUE_LOW   = 3'd0;
  localparam reg_index_t REG_BLUE_HIGH  = 3'd1;
  localparam reg_index_t REG_GREEN_LOW  = 3'd2;
  localparam reg_index_t REG_GREEN_HIGH = 3'd3;
  localparam reg_index_t REG_RED_LOW    = 3'd4;
  localparam reg_index_t REG_RED_HIGH   = 3'd5;
  localparam reg_index_t REG_RUN_LIMIT  = 3'd6;

  localparam logic [CHAN_W-1:0] RESET_LOW   = 8'd253;
  localparam logic [CHAN_W-1:0] RESET_HIGH  = 8'd255;
  localparam logic [RUN_W-1:0]  RESET_LIMIT = 4'd5;

endpackage

### rtl/caption_presence_detector_top.sv
// Caption presence detector: per-pixel whitish test, signature and frame status.
//
// Takes one BGR pixel of the watch window per clock. Each pixel is judged and
// counted in the cycle it transfers, so pixels stream with no gaps. Only the
// pixel carrying frame_end produces a status, held in a single result register;
// every pixel waits while a previous status sits there untaken. A status
// appears in the cycle after its frame_end pixel transfers. Configure only while
// no pixels are flowing and no status is pending.
`include "caption_presence_detector_top_macros.svh"

module caption_presence_detector_top #(
  parameter int MAX_WINDOW_PIXELS = cpd_pkg::MAX_WINDOW_PIXELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cpd_pkg::INDEX_W-1:0] cfg_index,
  input  logic [cpd_pkg::CHAN_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cpd_pkg::CHAN_W-1:0]  blue,
  input  logic [cpd_pkg::CHAN_W-1:0]  green,
  input  logic [cpd_pkg::CHAN_W-1:0]  red,
  input  logic                        line_end,
  input  logic                        frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cpd_pkg::status_t            frame_status
);

  localparam int SigCap = (MAX_WINDOW_PIXELS < cpd_pkg::SIG_WIDTH_MAX) ?
                          MAX_WINDOW_PIXELS : cpd_pkg::SIG_WIDTH_MAX;
  localparam int SigW   = $clog2(SigCap + 1);
  localparam logic [SigW-1:0] SigMax = SigW'(SigCap);

  logic [cpd_pkg::CHAN_W-1:0] blue_low, blue_high;
  logic [cpd_pkg::CHAN_W-1:0] green_low, green_high;
  logic [cpd_pkg::CHAN_W-1:0] red_low, red_high;
  logic [cpd_pkg::RUN_W-1:0]  run_limit;

  logic [SigW-1:0]           previous_signature, previous_signature_next;
  logic [SigW-1:0]           current_signature, current_signature_next;
  logic [cpd_pkg::RUN_W-1:0] whitish_run, whitish_run_next;
  logic                      short_run_seen, short_run_seen_next;
  logic                      frozen, frozen_next;
  cpd_pkg::status_t          status_next;

  logic in_take;
  logic whitish;
  logic lend;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      blue_low   <= cpd_pkg::RESET_LOW;
      blue_high  <= cpd_pkg::RESET_HIGH;
      green_low  <= cpd_pkg::RESET_LOW;
      green_high <= cpd_pkg::RESET_HIGH;
      red_low    <= cpd_pkg::RESET_LOW;
      red_high   <= cpd_pkg::RESET_HIGH;
      run_limit  <= cpd_pkg::RESET_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        cpd_pkg::REG_BLUE_LOW:   blue_low   <= cfg_data;
        cpd_pkg::REG_BLUE_HIGH:  blue_high  <= cfg_data;
        cpd_pkg::REG_GREEN_LOW:  green_low  <= cfg_data;
        cpd_pkg::REG_GREEN_HIGH: green_high <= cfg_data;
        cpd_pkg::REG_RED_LOW:    red_low    <= cfg_data;
        cpd_pkg::REG_RED_HIGH:   red_high   <= cfg_data;
        cpd_pkg::REG_RUN_LIMIT:  run_limit  <= cfg_data[cpd_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;
  assign lend     = line_end || frame_end;
  assign whitish  = (blue  >= blue_low)  && (blue  <= blue_high)  &&
                    (green >= green_low) && (green <= green_high) &&
                    (red   >= red_low)   && (red   <= red_high);

  always_comb begin
    previous_signature_next = previous_signature;
    current_signature_next  = current_signature;
    whitish_run_next        = whitish_run;
    short_run_seen_next     = short_run_seen;
    frozen_next             = frozen;
    status_next             = cpd_pkg::ST_SAME;

    if (!frozen) begin
      if (whitish) begin
        if (whitish_run < cpd_pkg::RUN_MAX) begin
          whitish_run_next = whitish_run + 1'b1;
        end
        if (current_signature < SigMax) begin
          current_signature_next = current_signature + 1'b1;
        end
      end else begin
        if ((whitish_run != '0) && (whitish_run < run_limit)) begin
          short_run_seen_next = 1'b1;
        end
        whitish_run_next = '0;
      end
      if (lend) begin
        whitish_run_next = '0;
        if (short_run_seen_next) begin
          frozen_next = 1'b1;
        end
      end
    end

    if (short_run_seen_next) begin
      if (previous_signature == '0) begin
        status_next = cpd_pkg::ST_START;
      end else if (previous_signature == current_signature_next) begin
        status_next = cpd_pkg::ST_SAME;
      end else begin
        status_next = cpd_pkg::ST_CHANGE;
      end
    end else begin
      status_next = (previous_signature == '0) ? cpd_pkg::ST_SAME : cpd_pkg::ST_END;
    end

    // Roll the signature over at frame end.
    if (frame_end) begin
      previous_signature_next = current_signature_next;
      current_signature_next  = '0;
      whitish_run_next        = '0;
      short_run_seen_next     = 1'b0;
      frozen_next             = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_signature <= '0;
      current_signature  <= '0;
      whitish_run        <= '0;
      short_run_seen     <= 1'b0;
      frozen             <= 1'b0;
    end else if (in_take) begin
      previous_signature <= previous_signature_next;
      current_signature  <= current_signature_next;
      whitish_run        <= whitish_run_next;
      short_run_seen     <= short_run_seen_next;
      frozen             <= frozen_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && frame_end) begin
      frame_status <= status_next;
    end
  end

  `CPD_ASSERT_RUN(a_frame_end_reports, in_take && frame_end |=> out_valid,
                  "frame end gave no status")
  `CPD_ASSERT_RUN(a_frame_end_clears,
                  in_take && frame_end |=> current_signature == '0 && !frozen && !short_run_seen,
                  "frame state not cleared")
  `CPD_ASSERT_ALWAYS(a_frozen_needs_text, frozen |-> short_run_seen, "frozen without text")
  `CPD_ASSERT_RUN(a_sig_capped, current_signature <= SigMax, "signature above cap")
  `CPD_ASSERT_RUN(a_stall_blocks_input, out_valid && !out_ready |-> !in_ready,
                  "input taken while status stalled")

endmodule
